@@ design/assert_macros.svh @@
// Assertion macros shared by the three-byte message parser RTL.
// Depends on nothing; compiled away when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// a holds in a cycle -> b holds in the same cycle
`define ASSERT_IMPLY(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");
// a holds in a cycle -> b holds in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLY(label, clk, rst_n, a, b)
`define ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

@@ design/mtmp_pkg.sv @@
// Types and constants of the three-byte message parser.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package mtmp_pkg;

    localparam logic [7:0] STATUS_FLAG     = 8'h80;
    localparam logic [7:0] HI_NIBBLE_MASK  = 8'hF0;
    localparam logic [7:0] LO_NIBBLE_MASK  = 8'h0F;
    localparam logic [7:0] STATUS_NOTE_OFF = 8'h80;
    localparam logic [7:0] STATUS_NOTE_ON  = 8'h90;
    localparam logic [7:0] STATUS_CTRL     = 8'hB0;

    localparam logic [1:0] POS_STATUS = 2'd0;
    localparam logic [1:0] POS_DATA1  = 2'd1;
    localparam logic [1:0] POS_DATA2  = 2'd2;

    localparam int CMD_DEPTH = 2;

    typedef enum logic [1:0] {
        KIND_ON    = 2'd0,
        KIND_OFF   = 2'd1,
        KIND_CC    = 2'd2,
        KIND_OTHER = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        OP_NONE    = 2'd0,
        OP_ADD_ON  = 2'd1,
        OP_ADD_OFF = 2'd2
    } acc_op_t;

    typedef struct packed {
        logic [1:0] port;
        logic [7:0] rx_byte;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  event_port;
        logic [1:0]  event_kind;
        logic [3:0]  midi_channel;
        logic [7:0]  first_data;
        logic [7:0]  second_data;
        logic [7:0]  status_byte;
        logic [15:0] on_accumulator;
        logic [15:0] off_accumulator;
    } out_item_t;

    // classified message handed from the front to the back
    typedef struct packed {
        logic [1:0] port;
        kind_t      kind;
        acc_op_t    op;
        logic [3:0] channel;
        logic [7:0] first_data;
        logic [7:0] second_data;
        logic [7:0] status_byte;
    } msg_t;

endpackage

@@ design/mtmp_front.sv @@
// Front end: per-port byte position and message buffer, message classification.
// Depends on mtmp_pkg.
`timescale 1ns / 1ps

module mtmp_front #(
    parameter int NUM_PORTS = 3
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  mtmp_pkg::in_item_t request,
    output logic              msg_push,
    output mtmp_pkg::msg_t    msg
);
    import mtmp_pkg::*;

    localparam int PIDX_W = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;

    logic [1:0]        pos_reg    [NUM_PORTS];
    logic [7:0]        status_reg [NUM_PORTS];
    logic [7:0]        data1_reg  [NUM_PORTS];

    logic [PIDX_W-1:0] pidx;
    logic              in_range;
    logic              is_status;
    logic [1:0]        cur_pos;
    logic [1:0]        new_pos;
    logic              complete;
    logic [7:0]        status;

    assign pidx      = PIDX_W'(request.port);
    assign in_range  = (int'(request.port) < NUM_PORTS);
    assign is_status = (request.rx_byte & STATUS_FLAG) != 8'h00;
    assign cur_pos   = in_range ? pos_reg[pidx] : POS_STATUS;
    assign status    = in_range ? status_reg[pidx] : 8'h00;

    always_comb
    begin
        if (is_status)
        begin
            new_pos = POS_STATUS;
        end
        else if (cur_pos == POS_DATA2)
        begin
            new_pos = POS_DATA2;
        end
        else
        begin
            new_pos = cur_pos + 2'd1;
        end
    end

    assign complete = accept && in_range && (new_pos == POS_DATA2);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_PORTS; i++)
            begin
                pos_reg[i]    <= POS_STATUS;
                status_reg[i] <= 8'h00;
                data1_reg[i]  <= 8'h00;
            end
        end
        else if (accept && in_range)
        begin
            pos_reg[pidx] <= complete ? POS_STATUS : new_pos;
            if (new_pos == POS_STATUS)
            begin
                status_reg[pidx] <= request.rx_byte;
            end
            if (new_pos == POS_DATA1)
            begin
                data1_reg[pidx] <= request.rx_byte;
            end
        end
    end

    // classification of the completed message
    always_comb
    begin
        msg.port        = request.port;
        msg.channel     = 4'(status & LO_NIBBLE_MASK);
        msg.first_data  = in_range ? data1_reg[pidx] : 8'h00;
        msg.second_data = request.rx_byte;
        msg.status_byte = status;
        unique case (status & HI_NIBBLE_MASK)
            STATUS_NOTE_ON:
            begin
                msg.op   = OP_ADD_ON;
                msg.kind = (request.rx_byte == 8'h00) ? KIND_OFF : KIND_ON;
            end
            STATUS_NOTE_OFF:
            begin
                msg.op   = OP_ADD_OFF;
                msg.kind = KIND_OFF;
            end
            STATUS_CTRL:
            begin
                msg.op   = OP_ADD_OFF;
                msg.kind = KIND_CC;
            end
            default:
            begin
                msg.op   = OP_NONE;
                msg.kind = KIND_OTHER;
            end
        endcase
    end

    assign msg_push = complete;

endmodule

@@ design/mtmp_fifo.sv @@
// Short message queue between the front end and the back end.
// Depends on mtmp_pkg.
`timescale 1ns / 1ps

module mtmp_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  mtmp_pkg::msg_t din,
    input  logic           pop,
    output logic           full,
    output logic           valid,
    output mtmp_pkg::msg_t dout
);
    import mtmp_pkg::*;

    localparam int PTR_W = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
    localparam int CNT_W = $clog2(CMD_DEPTH + 1);

    msg_t             slot_reg [CMD_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNT_W'(CMD_DEPTH));
    assign valid   = (count_reg != '0);
    assign dout    = slot_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(CMD_DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(CMD_DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

@@ design/mtmp_back.sv @@
// Back end: per-port channel accumulators and the result register.
// Depends on mtmp_pkg.
`timescale 1ns / 1ps

module mtmp_back #(
    parameter int NUM_PORTS = 3
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                msg_valid,
    input  mtmp_pkg::msg_t      msg,
    output logic                msg_take,
    input  logic                pop,
    output logic                empty,
    output mtmp_pkg::out_item_t result
);
    import mtmp_pkg::*;

    localparam int PIDX_W = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;

    logic [15:0]       on_sum_reg  [NUM_PORTS];
    logic [15:0]       off_sum_reg [NUM_PORTS];
    logic              out_valid_reg, out_valid_next;
    out_item_t         out_item_reg;

    logic [PIDX_W-1:0] pidx;
    logic [15:0]       chan_bit;
    logic [15:0]       on_new;
    logic [15:0]       off_new;

    assign pidx     = PIDX_W'(msg.port);
    assign chan_bit = 16'd1 << msg.channel;
    assign on_new   = on_sum_reg[pidx]  + ((msg.op == OP_ADD_ON)  ? chan_bit : 16'd0);
    assign off_new  = off_sum_reg[pidx] + ((msg.op == OP_ADD_OFF) ? chan_bit : 16'd0);

    assign msg_take = msg_valid && (!out_valid_reg || pop);

    always_comb
    begin
        if (msg_take)
        begin
            out_valid_next = 1'b1;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_PORTS; i++)
            begin
                on_sum_reg[i]  <= 16'd0;
                off_sum_reg[i] <= 16'd0;
            end
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (msg_take)
            begin
                on_sum_reg[pidx]  <= on_new;
                off_sum_reg[pidx] <= off_new;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (msg_take)
        begin
            out_item_reg.event_port      <= msg.port;
            out_item_reg.event_kind      <= msg.kind;
            out_item_reg.midi_channel    <= msg.channel;
            out_item_reg.first_data      <= msg.first_data;
            out_item_reg.second_data     <= msg.second_data;
            out_item_reg.status_byte     <= msg.status_byte;
            out_item_reg.on_accumulator  <= on_new;
            out_item_reg.off_accumulator <= off_new;
        end
    end

    assign empty  = !out_valid_reg;
    assign result = out_item_reg;

endmodule

@@ design/midi_three_byte_message_parser.sv @@
// Top level of the three-byte MIDI channel message parser with running status.
// Depends on mtmp_pkg, mtmp_front, mtmp_fifo, mtmp_back and assert_macros.svh.
`timescale 1ns / 1ps

// Takes one received byte per request, tagged with its input port, and keeps a
// byte position and message buffer per port. A status byte restarts the
// message; the second data byte completes it, and later data bytes reuse the
// stored status (running status). Each completed message yields one result
// with its kind (note on, note off including note on with velocity zero,
// control change, other), channel, data bytes and the port's updated 16-bit
// wrapping note-on and note-off/CC channel accumulators. Bytes from a port
// index at or above NUM_PORTS are dropped. Rate: one request per cycle while
// full is low. A completed message is classified in the front, held in the
// message queue and loaded into the result register. full rises only when
// the two-entry message queue fills because results are not popped.

`include "assert_macros.svh"

module midi_three_byte_message_parser #(
    parameter int NUM_PORTS = 3
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  mtmp_pkg::in_item_t  request,
    output logic                empty,
    input  logic                pop,
    output mtmp_pkg::out_item_t result
);
    import mtmp_pkg::*;

    logic accept;
    logic msg_push;
    msg_t msg_in;
    logic msg_valid;
    msg_t msg_out;
    logic msg_take;

    // a request is taken whenever the message queue has room
    assign accept = push && !full;

    // front: position tracking and classification
    mtmp_front #(
        .NUM_PORTS (NUM_PORTS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .request  (request),
        .msg_push (msg_push),
        .msg      (msg_in)
    );

    // decoupling queue between classification and accumulation
    mtmp_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (msg_push),
        .din   (msg_in),
        .pop   (msg_take),
        .full  (full),
        .valid (msg_valid),
        .dout  (msg_out)
    );

    // back: accumulators and result register
    mtmp_back #(
        .NUM_PORTS (NUM_PORTS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .msg_valid (msg_valid),
        .msg       (msg_out),
        .msg_take  (msg_take),
        .pop       (pop),
        .empty     (empty),
        .result    (result)
    );

    // a completed message is only produced for a request that was taken
    `ASSERT_IMPLY(a_push_needs_room, clk, rst_n, msg_push, accept)
    // a status byte never completes a message
    `ASSERT_IMPLY(a_status_no_msg, clk, rst_n, accept && request.rx_byte[7], !msg_push)
    // the back end only loads the result register when it is free or drained
    `ASSERT_IMPLY(a_take_when_free, clk, rst_n, msg_take, empty || pop)
    // a message taken by the back end is offered as a result next cycle
    `ASSERT_NEXT(a_take_shows, clk, rst_n, msg_take, !empty)

endmodule
